// ===== hw/rtl/kmd_pkg.sv =====
// ============================================================================
// kmd_pkg
// Shared key state codes, register indexes and reset values for the key
// matrix debounce block.
// ============================================================================
package kmd_pkg;

    localparam int STATE_W = 3;
    localparam int TIME_W  = 8;

    // Key state codes as stored and as reported.
    localparam logic [STATE_W-1:0] ST_OFF     = 3'd0;
    localparam logic [STATE_W-1:0] ST_PRESS   = 3'd1;
    localparam logic [STATE_W-1:0] ST_HOLD    = 3'd2;
    localparam logic [STATE_W-1:0] ST_RELEASE = 3'd3;
    localparam logic [STATE_W-1:0] ST_INVALID = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MIN_MS    = 1'b1;

    localparam logic [15:0] THRESHOLD_RESET = 16'hFFFF;
    localparam logic [7:0]  MIN_MS_RESET    = 8'd5;

    // Outcome of one key update.
    typedef struct packed {
        logic                valid;
        logic [STATE_W-1:0]  state;
    } kmd_result_t;

endpackage

// ===== hw/rtl/kmd_ram.sv =====
// ============================================================================
// kmd_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/kmd_update.sv =====
// ============================================================================
// kmd_update
// Per-key debounce update: count update, period rollover and classification.
// ============================================================================
module kmd_update #(
    parameter int COUNT_BITS = 16
) (
    input  logic [kmd_pkg::STATE_W-1:0] prev_state,
    input  logic [kmd_pkg::STATE_W-1:0] cur_state,
    input  logic [COUNT_BITS-1:0]       active_count,
    input  logic [COUNT_BITS-1:0]       inactive_count,
    input  logic [kmd_pkg::TIME_W-1:0]  decision_time,
    input  logic                        sensed,
    input  logic                        period_start,
    input  logic [kmd_pkg::TIME_W-1:0]  time_ms,
    input  logic [COUNT_BITS-1:0]       count_limit,
    input  logic [7:0]                  min_decision_ms,
    output logic [kmd_pkg::STATE_W-1:0] new_prev_state,
    output logic [kmd_pkg::STATE_W-1:0] new_cur_state,
    output logic [COUNT_BITS-1:0]       new_active_count,
    output logic [COUNT_BITS-1:0]       new_inactive_count,
    output logic [kmd_pkg::TIME_W-1:0]  new_decision_time,
    output kmd_pkg::kmd_result_t        result
);

    logic [kmd_pkg::STATE_W-1:0] cur_roll;
    logic [kmd_pkg::TIME_W-1:0]  elapsed;
    logic                        more_active;
    logic                        too_soon;
    logic                        blocked;
    logic [kmd_pkg::STATE_W-1:0] decided;

    // A new period moves the current state to previous and leaves the key undecided.
    assign new_prev_state = period_start ? cur_state : prev_state;
    assign cur_roll       = period_start ? kmd_pkg::ST_INVALID : cur_state;

    always_comb
    begin
        if (sensed)
        begin
            new_active_count   = (active_count < count_limit)
                                 ? active_count + 1'b1 : active_count;
            new_inactive_count = inactive_count >> 1;
        end
        else
        begin
            new_inactive_count = (inactive_count < count_limit)
                                 ? inactive_count + 1'b1 : inactive_count;
            new_active_count   = active_count >> 1;
        end
    end

    assign more_active = new_active_count > new_inactive_count;
    assign elapsed     = time_ms - decision_time;
    assign too_soon    = elapsed < min_decision_ms;

    always_comb
    begin
        blocked = 1'b0;
        decided = kmd_pkg::ST_INVALID;
        unique case (new_prev_state)
            kmd_pkg::ST_PRESS, kmd_pkg::ST_HOLD:
            begin
                if (more_active)
                begin
                    decided = kmd_pkg::ST_HOLD;
                end
                else
                begin
                    blocked = too_soon;
                    decided = kmd_pkg::ST_RELEASE;
                end
            end
            kmd_pkg::ST_RELEASE, kmd_pkg::ST_OFF:
            begin
                if (more_active)
                begin
                    blocked = too_soon;
                    decided = kmd_pkg::ST_PRESS;
                end
                else
                begin
                    decided = kmd_pkg::ST_OFF;
                end
            end
            default:
            begin
                decided = kmd_pkg::ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        new_cur_state     = cur_roll;
        new_decision_time = decision_time;
        result.valid      = 1'b0;
        result.state      = decided;
        if (cur_roll == kmd_pkg::ST_INVALID)
        begin
            if (blocked)
            begin
                // Too early for a change: the key silently keeps its old state.
                new_cur_state = new_prev_state;
            end
            else
            begin
                new_cur_state     = decided;
                new_decision_time = time_ms;
                result.valid      = 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/key_matrix_debounce_state.sv =====
// ============================================================================
// key_matrix_debounce_state
// Counter-based key matrix debounce with a per-key state record.
// ============================================================================
// Path: an accepted item is registered in stage 1 as its key record is read;
// the record is updated and written back, and the result register loaded,
// when stage 1 advances. Throughput: one item per cycle unless the result
// stream stalls, set by the single read and single write port of the key
// record RAM; a back-to-back item for the same key is forwarded.
// Reset: control state and configuration clear at once; each key has a valid
// bit, so no clearing pass is run and the block takes items right after reset.
module key_matrix_debounce_state #(
    parameter int KEY_COUNT  = 128,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input item stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_index[6:0], sensed[7], period_start[8],
                                   // time_ms[16:9], zero fill [23:17]

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // key_number[7:0], key_state[10:8],
                                   // zero fill [15:11]

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ADDR_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int SW     = kmd_pkg::STATE_W;
    localparam int TW     = kmd_pkg::TIME_W;
    localparam int REC_W  = 2 * SW + 2 * COUNT_BITS + TW;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Record layout, lowest bits first: previous state, current state,
    // active count, inactive count, decision time.
    localparam logic [REC_W-1:0] REC_RESET =
        {{TW{1'b0}}, COUNT_MAX, {COUNT_BITS{1'b0}}, kmd_pkg::ST_OFF, kmd_pkg::ST_OFF};

    // ------------------------------------------------------------------------
    // Config regs: user must issue writes only while idle; the block won't check.
    // ------------------------------------------------------------------------
    logic [15:0] threshold_reg;
    logic [7:0]  min_ms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= kmd_pkg::THRESHOLD_RESET;
            min_ms_reg    <= kmd_pkg::MIN_MS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                kmd_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                kmd_pkg::CFG_MIN_MS:    min_ms_reg    <= cfg_data[7:0];
                default:                min_ms_reg    <= min_ms_reg;
            endcase
        end
    end

    // The counts saturate at the smaller of the threshold and the count range.
    logic [31:0]           threshold_wide;
    logic [COUNT_BITS-1:0] count_limit;

    assign threshold_wide = 32'(threshold_reg);
    assign count_limit    = (threshold_wide > 32'(COUNT_MAX))
                            ? COUNT_MAX : COUNT_BITS'(threshold_wide);

    // ------------------------------------------------------------------------
    // Input register stage. Accepting an item also launches the RAM read.
    // ------------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [6:0]  s1_key_reg;
    logic        s1_sensed_reg;
    logic        s1_start_reg;
    logic [7:0]  s1_time_reg;
    logic        s1_entry_valid_reg;
    logic        hit_reg;
    logic [REC_W-1:0] bypass_reg;

    logic        out_valid_reg;
    logic [7:0]  out_number_reg;
    logic [SW-1:0] out_state_reg;

    logic        accept;
    logic        advance;
    logic        s1_in_range;
    logic        write_en;
    logic        hit_next;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] s1_addr;
    logic [REC_W-1:0]  ram_rd_data;
    logic [REC_W-1:0]  rec_cur;
    logic [REC_W-1:0]  rec_new;
    logic [KEY_COUNT-1:0] entry_valid_reg;
    kmd_pkg::kmd_result_t result;

    // Stage 1 moves on when the result register is free or being emptied.
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign rd_addr     = ADDR_W'(s_tdata[6:0]);
    assign s1_addr     = ADDR_W'(s1_key_reg);
    assign s1_in_range = 32'(s1_key_reg) < KEY_COUNT;
    assign write_en    = advance && s1_in_range;

    // The RAM read of the next item happens at the same edge as this item's
    // write, so it returns stale data for the same key; forward instead.
    assign hit_next = write_en && (s_tdata[6:0] == s1_key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            hit_reg      <= hit_next;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg         <= s_tdata[6:0];
            s1_sensed_reg      <= s_tdata[7];
            s1_start_reg       <= s_tdata[8];
            s1_time_reg        <= s_tdata[16:9];
            s1_entry_valid_reg <= entry_valid_reg[rd_addr];
            bypass_reg         <= rec_new;
        end
    end

    // One valid bit per key; an entry never written reads as the reset record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (write_en)
        begin
            entry_valid_reg[s1_addr] <= 1'b1;
        end
    end

    kmd_ram #(
        .WIDTH (REC_W),
        .DEPTH (KEY_COUNT)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (write_en),
        .wr_addr (s1_addr),
        .wr_data (rec_new),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        priority if (hit_reg)
        begin
            rec_cur = bypass_reg;
        end
        else if (s1_entry_valid_reg)
        begin
            rec_cur = ram_rd_data;
        end
        else
        begin
            rec_cur = REC_RESET;
        end
    end

    // ------------------------------------------------------------------------
    // Per-key update.
    // ------------------------------------------------------------------------
    kmd_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .prev_state         (rec_cur[0 +: SW]),
        .cur_state          (rec_cur[SW +: SW]),
        .active_count       (rec_cur[2*SW +: COUNT_BITS]),
        .inactive_count     (rec_cur[2*SW+COUNT_BITS +: COUNT_BITS]),
        .decision_time      (rec_cur[2*SW+2*COUNT_BITS +: TW]),
        .sensed             (s1_sensed_reg),
        .period_start       (s1_start_reg),
        .time_ms            (s1_time_reg),
        .count_limit        (count_limit),
        .min_decision_ms    (min_ms_reg),
        .new_prev_state     (rec_new[0 +: SW]),
        .new_cur_state      (rec_new[SW +: SW]),
        .new_active_count   (rec_new[2*SW +: COUNT_BITS]),
        .new_inactive_count (rec_new[2*SW+COUNT_BITS +: COUNT_BITS]),
        .new_decision_time  (rec_new[2*SW+2*COUNT_BITS +: TW]),
        .result             (result)
    );

    // ------------------------------------------------------------------------
    // Result register. Out-of-range keys and undecided outcomes give no item.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.valid && s1_in_range;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_number_reg <= {1'b0, s1_key_reg} + 8'd1;
            out_state_reg  <= result.state;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_state_reg, out_number_reg};

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_hit_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> s1_valid_reg)
        else $error("forwarding flag set with no item in stage 1");

    a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while stage 1 is stalled");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_state_reg <= kmd_pkg::ST_INVALID))
        else $error("reported key state out of range");

    a_key_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_number_reg != 8'd0 && 32'(out_number_reg) <= KEY_COUNT))
        else $error("reported key number out of range");

    a_write_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        write_en |-> s1_valid_reg)
        else $error("record written with no item in stage 1");

endmodule
